/* sv/oaht_pkg.sv */
`timescale 1ns / 1ps

package oaht_pkg;

	localparam int TABLE_SIZE = 61;
	localparam int KEY_BITS   = 12;
	localparam int VALUE_BITS = 32;
	localparam int SLOT_BITS  = 6;
	localparam int STEP_BITS  = 4;
	localparam int STEP_MOD   = 10;

	// Reciprocal multipliers, rounded down, for the key remainders.
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_TABLE = 1074;
	localparam int RECIP_STEP  = 6553;

	typedef logic [1:0] status_t;

	localparam status_t ST_INSERTED  = 2'd0;
	localparam status_t ST_FOUND     = 2'd1;
	localparam status_t ST_NOT_FOUND = 2'd2;
	localparam status_t ST_FULL      = 2'd3;

	typedef logic [SLOT_BITS-1:0] slot_t;
	typedef logic [KEY_BITS-1:0]  key_t;
	typedef logic [VALUE_BITS-1:0] value_t;

endpackage

/* sv/open_addressing_hash_table.sv */
`timescale 1ns / 1ps

// A zero key finishes in S_MUL without probing; any other key passes through
// S_MUL, S_FIX and S_RD and then probes P slots in S_CMP (P from 1 to 61).
// A new transaction is taken only back in S_IDLE; while probing, one slot is read
// and compared per cycle through the single table read port and position adder.
// Reset clears control state and the slot occupancy bits at once; no sweep.
module open_addressing_hash_table (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     kind,
	input  oaht_pkg::key_t           key,
	input  oaht_pkg::value_t         value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output oaht_pkg::status_t        status,
	output oaht_pkg::slot_t          slot,
	output oaht_pkg::slot_t          probe_length,
	output oaht_pkg::value_t         found_value
);
	import oaht_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_FIX  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_CMP  = 3'd4;

	localparam int QT_BITS = KEY_BITS + 1 - 6;
	localparam int QS_BITS = KEY_BITS + 1 - 4;
	localparam int RT_BITS = KEY_BITS + 1;

	logic [2:0]         state_q;
	logic               kind_q;
	key_t               key_q;
	value_t             value_q;
	logic [QT_BITS-1:0] qt_q;
	logic [QS_BITS-1:0] qs_q;
	slot_t              pos_q;
	logic [STEP_BITS-1:0] stride_q;
	slot_t              n_q;

	key_t   key_mem [0:TABLE_SIZE-1];
	value_t val_mem [0:TABLE_SIZE-1];
	logic [TABLE_SIZE-1:0] vld_q;

	key_t   rd_key_q;
	value_t rd_val_q;
	logic   rd_vld_q;
	slot_t  rd_addr;

	logic       out_valid_q;
	status_t    status_q;
	slot_t      slot_q;
	slot_t      plen_q;
	value_t     fval_q;

	logic [RT_BITS-1:0] rt_w;
	logic [RT_BITS-1:0] rs_w;
	slot_t              home_w;
	logic [STEP_BITS-1:0] stride_w;
	logic [SLOT_BITS:0] sum_w;
	slot_t              pos_adv;
	key_t               cur_key;
	logic               out_free;
	logic               fin;
	logic               advance;
	logic               wr_en;
	status_t            fin_status;
	slot_t              fin_slot;
	slot_t              fin_plen;
	value_t             fin_val;

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign slot         = slot_q;
	assign probe_length = plen_q;
	assign found_value  = fval_q;
	assign out_free     = !out_valid_q || out_ready;

	always_comb begin
		rt_w = RT_BITS'(key_q) - RT_BITS'(RT_BITS'(qt_q) * RT_BITS'(TABLE_SIZE));
		rs_w = RT_BITS'(key_q) - RT_BITS'(RT_BITS'(qs_q) * RT_BITS'(STEP_MOD));
		if (rt_w >= RT_BITS'(TABLE_SIZE)) begin
			home_w = SLOT_BITS'(rt_w - RT_BITS'(TABLE_SIZE));
		end else begin
			home_w = SLOT_BITS'(rt_w);
		end
		if (rs_w >= RT_BITS'(STEP_MOD)) begin
			stride_w = STEP_BITS'(rs_w - RT_BITS'(STEP_MOD)) + STEP_BITS'(1);
		end else begin
			stride_w = STEP_BITS'(rs_w) + STEP_BITS'(1);
		end
	end

	always_comb begin
		sum_w = (SLOT_BITS+1)'(pos_q) + (SLOT_BITS+1)'(stride_q);
		if (sum_w >= (SLOT_BITS+1)'(TABLE_SIZE)) begin
			pos_adv = SLOT_BITS'(sum_w - (SLOT_BITS+1)'(TABLE_SIZE));
		end else begin
			pos_adv = SLOT_BITS'(sum_w);
		end
		cur_key = rd_vld_q ? rd_key_q : '0;
	end

	always_comb begin
		fin        = 1'b0;
		wr_en      = 1'b0;
		fin_status = ST_NOT_FOUND;
		fin_slot   = '0;
		fin_plen   = '0;
		fin_val    = '0;
		case (state_q)
			S_MUL: begin
				fin = (key_q == '0);
			end
			S_CMP: begin
				if (kind_q == 1'b0 && cur_key == '0) begin
					fin        = 1'b1;
					wr_en      = out_free;
					fin_status = ST_INSERTED;
					fin_slot   = pos_q;
					fin_plen   = n_q;
				end else if (kind_q == 1'b1 && cur_key == key_q) begin
					fin        = 1'b1;
					fin_status = ST_FOUND;
					fin_slot   = pos_q;
					fin_plen   = n_q;
					fin_val    = rd_val_q;
				end else if (kind_q == 1'b1 && cur_key == '0) begin
					fin        = 1'b1;
					fin_plen   = n_q;
				end else if (n_q == SLOT_BITS'(TABLE_SIZE)) begin
					fin        = 1'b1;
					fin_status = (kind_q == 1'b0) ? ST_FULL : ST_NOT_FOUND;
					fin_plen   = n_q;
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
		advance = (state_q == S_CMP) && !fin;
		rd_addr = advance ? pos_adv : pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fin && out_free) begin
				out_valid_q <= 1'b1;
			end
			if (wr_en) begin
				vld_q[pos_q] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (!fin) begin
						state_q <= S_FIX;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_FIX: begin
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (fin && out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			kind_q  <= kind;
			key_q   <= key;
			value_q <= value;
		end
		if (state_q == S_MUL) begin
			qt_q <= QT_BITS'((23'(key_q) * 23'(RECIP_TABLE)) >> RECIP_SHIFT);
			qs_q <= QS_BITS'((25'(key_q) * 25'(RECIP_STEP)) >> RECIP_SHIFT);
		end
		if (state_q == S_FIX) begin
			pos_q    <= home_w;
			stride_q <= stride_w;
			n_q      <= SLOT_BITS'(1);
		end
		if (advance) begin
			pos_q <= pos_adv;
			n_q   <= n_q + SLOT_BITS'(1);
		end
		if (fin && out_free) begin
			status_q <= fin_status;
			slot_q   <= fin_slot;
			plen_q   <= fin_plen;
			fval_q   <= fin_val;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[pos_q] <= key_q;
			val_mem[pos_q] <= value_q;
		end
		rd_key_q <= key_mem[rd_addr];
		rd_val_q <= val_mem[rd_addr];
		rd_vld_q <= vld_q[rd_addr];
	end

endmodule
